### hw/rtl/sss_pkg.sv
// Shared types, codes and reset constants of the servo strike sequencer.
`timescale 1ns / 1ps

package sss_pkg;

    // Sequence phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_DELAY  = 3'd1;
    localparam logic [2:0] PH_STRIKE = 3'd2;
    localparam logic [2:0] PH_HOLD   = 3'd3;
    localparam logic [2:0] PH_RETURN = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_STRIKE_DELAY = 3'd0;
    localparam logic [2:0] REG_STRIKE_HOLD  = 3'd1;
    localparam logic [2:0] REG_STEP_IVL     = 3'd2;
    localparam logic [2:0] REG_STEP_DEG     = 3'd3;
    localparam logic [2:0] REG_STRIKE_ANGLE = 3'd4;
    localparam logic [2:0] REG_LEFT_REST    = 3'd5;
    localparam logic [2:0] REG_RIGHT_REST   = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [15:0] RST_STRIKE_DELAY = 16'd100;
    localparam logic [15:0] RST_STRIKE_HOLD  = 16'd300;
    localparam logic [15:0] RST_STEP_IVL     = 16'd10;
    localparam logic [7:0]  RST_STEP_DEG     = 8'd5;
    localparam logic [7:0]  RST_STRIKE_ANGLE = 8'd90;
    localparam logic [7:0]  RST_LEFT_REST    = 8'd175;
    localparam logic [7:0]  RST_RIGHT_REST   = 8'd5;

    // Command bytes: ASCII '1' and '4'
    localparam logic [7:0] CMD_FIRST = 8'h31;
    localparam logic [7:0] CMD_LAST  = 8'h34;

    typedef struct packed {
        logic [15:0] strike_delay_ms;
        logic [15:0] strike_hold_ms;
        logic [15:0] step_interval_ms;
        logic [7:0]  step_degrees;
        logic [7:0]  strike_angle;
        logic [7:0]  left_rest_angle;
        logic [7:0]  right_rest_angle;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  active_servo;
        logic        active_valid;
        logic [7:0]  current_angle;
        logic [7:0]  target_angle;
        logic [31:0] phase_start_ms;
        logic [31:0] last_step_ms;
        logic [3:0]  power_bits;
    } state_t;

    typedef struct packed {
        logic       byte_taken;
        logic       write_valid;
        logic [1:0] write_servo;
        logic [7:0] write_angle;
        logic [3:0] power_mask;
        logic [2:0] phase;
    } res_t;

endpackage

### hw/rtl/sss_cfg.sv
// Configuration register file of the servo strike sequencer.
`timescale 1ns / 1ps

module sss_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_data,
    output sss_pkg::cfg_t                  cfg
);

    sss_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strike_delay_ms  <= sss_pkg::RST_STRIKE_DELAY;
            cfg_reg.strike_hold_ms   <= sss_pkg::RST_STRIKE_HOLD;
            cfg_reg.step_interval_ms <= sss_pkg::RST_STEP_IVL;
            cfg_reg.step_degrees     <= sss_pkg::RST_STEP_DEG;
            cfg_reg.strike_angle     <= sss_pkg::RST_STRIKE_ANGLE;
            cfg_reg.left_rest_angle  <= sss_pkg::RST_LEFT_REST;
            cfg_reg.right_rest_angle <= sss_pkg::RST_RIGHT_REST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sss_pkg::REG_STRIKE_DELAY: cfg_reg.strike_delay_ms  <= cfg_data;
                sss_pkg::REG_STRIKE_HOLD:  cfg_reg.strike_hold_ms   <= cfg_data;
                sss_pkg::REG_STEP_IVL:     cfg_reg.step_interval_ms <= cfg_data;
                sss_pkg::REG_STEP_DEG:     cfg_reg.step_degrees     <= cfg_data[7:0];
                sss_pkg::REG_STRIKE_ANGLE: cfg_reg.strike_angle     <= cfg_data[7:0];
                sss_pkg::REG_LEFT_REST:    cfg_reg.left_rest_angle  <= cfg_data[7:0];
                sss_pkg::REG_RIGHT_REST:   cfg_reg.right_rest_angle <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/sss_step.sv
// Per-poll next-state and result logic of the servo strike sequencer.
`timescale 1ns / 1ps

module sss_step (
    input  sss_pkg::state_t st,
    input  sss_pkg::cfg_t   cfg,
    input  logic [31:0]     now_ms,
    input  logic            byte_valid,
    input  logic [7:0]      rx_byte,
    output sss_pkg::state_t st_next,
    output sss_pkg::res_t   res
);

    sss_pkg::state_t s;
    logic [31:0]     since_start;
    logic [31:0]     since_step;
    logic [7:0]      rest_angle;
    logic [8:0]      up_sum;
    logic [8:0]      down_limit;
    logic [7:0]      angle_new;
    logic [3:0]      servo_bit;

    always_comb
    begin
        s = st;
        res = '0;
        since_start = '0;
        since_step = '0;
        up_sum = '0;
        down_limit = '0;
        angle_new = '0;

        // Unused codes fall back to idle
        if (s.phase > sss_pkg::PH_RETURN)
            s.phase = sss_pkg::PH_IDLE;

        if (s.phase == sss_pkg::PH_IDLE && byte_valid)
        begin
            res.byte_taken = 1'b1;
            if (rx_byte >= sss_pkg::CMD_FIRST && rx_byte <= sss_pkg::CMD_LAST)
            begin
                s.active_servo   = 2'(rx_byte - sss_pkg::CMD_FIRST);
                s.active_valid   = 1'b1;
                s.phase          = sss_pkg::PH_DELAY;
                s.phase_start_ms = now_ms;
            end
        end

        rest_angle = s.active_servo[0] ? cfg.right_rest_angle : cfg.left_rest_angle;
        servo_bit  = 4'b0001 << s.active_servo;

        case (s.phase)
            sss_pkg::PH_DELAY:
            begin
                since_start = now_ms - s.phase_start_ms;
                if (since_start >= {16'd0, cfg.strike_delay_ms})
                begin
                    if (s.active_valid)
                    begin
                        s.current_angle = rest_angle;
                        s.target_angle  = cfg.strike_angle;
                        s.power_bits    = s.power_bits | servo_bit;
                        s.phase         = sss_pkg::PH_STRIKE;
                        s.last_step_ms  = now_ms;
                    end
                    else
                    begin
                        s.phase = sss_pkg::PH_IDLE;
                    end
                end
            end
            sss_pkg::PH_STRIKE:
            begin
                s.current_angle  = s.target_angle;
                res.write_valid  = 1'b1;
                res.write_servo  = s.active_servo;
                res.write_angle  = s.target_angle;
                s.phase          = sss_pkg::PH_HOLD;
                s.phase_start_ms = now_ms;
            end
            sss_pkg::PH_HOLD:
            begin
                since_start = now_ms - s.phase_start_ms;
                if (since_start >= {16'd0, cfg.strike_hold_ms})
                begin
                    s.target_angle = rest_angle;
                    s.phase        = sss_pkg::PH_RETURN;
                    s.last_step_ms = now_ms;
                end
            end
            sss_pkg::PH_RETURN:
            begin
                since_step = now_ms - s.last_step_ms;
                if (since_step >= {16'd0, cfg.step_interval_ms})
                begin
                    // Step toward the rest angle, clamp at it
                    up_sum     = {1'b0, s.current_angle} + {1'b0, cfg.step_degrees};
                    down_limit = {1'b0, s.target_angle} + {1'b0, cfg.step_degrees};
                    angle_new  = s.current_angle;
                    if (s.current_angle < s.target_angle)
                    begin
                        angle_new = (up_sum > {1'b0, s.target_angle}) ?
                                    s.target_angle : up_sum[7:0];
                    end
                    else if (s.current_angle > s.target_angle)
                    begin
                        angle_new = ({1'b0, s.current_angle} < down_limit) ?
                                    s.target_angle : s.current_angle - cfg.step_degrees;
                    end
                    s.current_angle = angle_new;
                    res.write_valid = 1'b1;
                    res.write_servo = s.active_servo;
                    res.write_angle = angle_new;
                    s.last_step_ms  = now_ms;
                    if (angle_new == s.target_angle)
                    begin
                        s.power_bits   = s.power_bits & ~servo_bit;
                        s.phase        = sss_pkg::PH_IDLE;
                        s.active_valid = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        res.power_mask = s.power_bits;
        res.phase      = s.phase;
        st_next        = s;
    end

endmodule

### hw/rtl/servo_strike_sequencer.sv
// Top level of the servo strike sequencer: input register, sequencer state, result register.
`timescale 1ns / 1ps

// Servo strike sequencer. Each input item is one poll: the free-running
// millisecond time now_ms and, when byte_valid is set, a waiting command
// byte rx_byte. In idle a waiting byte is always taken; ASCII '1' to '4'
// picks servo 0 to 3 and starts a strike: wait strike_delay_ms, attach the
// drive, jump to strike_angle on the next poll, hold for strike_hold_ms,
// then ramp back to the servo's rest angle by step_degrees every
// step_interval_ms (clamped at rest) and detach the drive. Every poll yields
// exactly one result item carrying byte_taken, the optional servo write,
// the drive mask and the phase after the poll. All time differences wrap
// at 32 bits. Rate: one item per clock while out_stall is low. An item is
// held in the input register, then the sequencer state and the result
// register update together in one pass. Stall from the output side backs
// up through both registers.
// Configuration registers (cfg_index 0..6) are written with cfg_we and take
// effect at once; write them only while the block is idle.
module servo_strike_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sss_pkg::CFG_DATA_W-1:0] cfg_data,
    // poll channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [31:0]                    now_ms,
    input  logic                           byte_valid,
    input  logic [7:0]                     rx_byte,
    // result channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           byte_taken,
    output logic                           write_valid,
    output logic [1:0]                     write_servo,
    output logic [7:0]                     write_angle,
    output logic [3:0]                     power_mask,
    output logic [2:0]                     phase
);

    sss_pkg::cfg_t   cfg;
    sss_pkg::state_t state_reg;
    sss_pkg::state_t state_next;
    sss_pkg::res_t   res_next;
    sss_pkg::res_t   res_reg;

    // Input register
    logic            in_vld_reg;
    logic [31:0]     now_reg;
    logic            bvalid_reg;
    logic [7:0]      byte_reg;

    logic            out_vld_reg;
    logic            advance;
    logic            in_take;

    sss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sss_step u_step (
        .st         (state_reg),
        .cfg        (cfg),
        .now_ms     (now_reg),
        .byte_valid (bvalid_reg),
        .rx_byte    (byte_reg),
        .st_next    (state_next),
        .res        (res_next)
    );

    // Advance the held poll into the result register when that slot is free
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // Hold the poll payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            now_reg    <= now_ms;
            bvalid_reg <= byte_valid;
            byte_reg   <= rx_byte;
        end
    end

    // Sequencer state moves once per processed poll
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign byte_taken  = res_reg.byte_taken;
    assign write_valid = res_reg.write_valid;
    assign write_servo = res_reg.write_servo;
    assign write_angle = res_reg.write_angle;
    assign power_mask  = res_reg.power_mask;
    assign phase       = res_reg.phase;

endmodule

### tb/sv/tb_servo_strike_sequencer.sv
// Self-checking testbench for the servo strike sequencer: queued polls, predictor, result check.
`timescale 1ns / 1ps

module tb_servo_strike_sequencer;

    // One poll as it is presented on the input channel
    typedef struct packed {
        logic [31:0] now_ms;
        logic        byte_valid;
        logic [7:0]  rx_byte;
    } poll_t;

    // Signals driven by the testbench start at known values
    logic                           clk        = 1'b0;
    logic                           rst_n      = 1'b0;
    logic                           cfg_we     = 1'b0;
    logic [sss_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [sss_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    logic                           in_valid   = 1'b0;
    logic [31:0]                    now_ms     = '0;
    logic                           byte_valid = 1'b0;
    logic [7:0]                     rx_byte    = '0;
    logic                           out_stall  = 1'b0;

    logic       in_stall;
    logic       out_valid;
    logic       byte_taken;
    logic       write_valid;
    logic [1:0] write_servo;
    logic [7:0] write_angle;
    logic [3:0] power_mask;
    logic [2:0] phase;

    servo_strike_sequencer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .now_ms      (now_ms),
        .byte_valid  (byte_valid),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .byte_taken  (byte_taken),
        .write_valid (write_valid),
        .write_servo (write_servo),
        .write_angle (write_angle),
        .power_mask  (power_mask),
        .phase       (phase)
    );

    // Polls waiting to be driven, and results the predictor says are due
    poll_t          poll_q[$];
    sss_pkg::res_t  due_results[$];

    // While set, neither side inserts bubbles or stalls
    bit steady = 1'b0;

    int unsigned mismatches = 0;
    int unsigned polls_sent = 0;
    int unsigned results_seen = 0;
    int unsigned writes_seen = 0;
    int unsigned strikes_started = 0;
    int unsigned settings_used = 0;

    // Running millisecond clock that the stimulus advances
    logic [31:0] t_ms;

    // Predictor copy of the configuration
    logic [15:0] dly_ms;
    logic [15:0] hold_ms;
    logic [15:0] ivl_ms;
    logic [7:0]  deg_step;
    logic [7:0]  strike_ang;
    logic [7:0]  left_rest;
    logic [7:0]  right_rest;

    // Predictor copy of the sequencer state
    logic [2:0]  seq_phase;
    logic [1:0]  seq_servo;
    logic        seq_armed;
    logic [7:0]  seq_cur;
    logic [7:0]  seq_tgt;
    logic [31:0] seq_mark;
    logic [31:0] seq_last_step;
    logic [3:0]  seq_power;

    initial forever #5 clk = ~clk;

    // Even servos park at the left rest angle, odd ones at the right
    function automatic logic [7:0] rest_angle(logic [1:0] servo);
        return servo[0] ? right_rest : left_rest;
    endfunction

    // Advance the predicted sequencer by one poll and return the result it yields
    function automatic sss_pkg::res_t sequence_poll(poll_t p);
        sss_pkg::res_t r;
        logic [8:0]    sum;
        r = '0;
        // Unused phase codes fall back to idle
        if (seq_phase > sss_pkg::PH_RETURN)
            seq_phase = sss_pkg::PH_IDLE;
        // In idle a waiting byte is always taken; only '1'..'4' arm a strike
        if (seq_phase == sss_pkg::PH_IDLE && p.byte_valid) begin
            r.byte_taken = 1'b1;
            if (p.rx_byte >= sss_pkg::CMD_FIRST && p.rx_byte <= sss_pkg::CMD_LAST) begin
                seq_servo = 2'(p.rx_byte - sss_pkg::CMD_FIRST);
                seq_armed = 1'b1;
                seq_phase = sss_pkg::PH_DELAY;
                seq_mark  = p.now_ms;
                strikes_started++;
            end
        end
        case (seq_phase)
            sss_pkg::PH_DELAY: begin
                // Zero delay falls through here in the same poll as the command
                if (p.now_ms - seq_mark >= {16'd0, dly_ms}) begin
                    if (seq_armed) begin
                        seq_cur       = rest_angle(seq_servo);
                        seq_tgt       = strike_ang;
                        seq_power     = seq_power | (4'b0001 << seq_servo);
                        seq_phase     = sss_pkg::PH_STRIKE;
                        seq_last_step = p.now_ms;
                    end else begin
                        seq_phase = sss_pkg::PH_IDLE;
                    end
                end
            end
            sss_pkg::PH_STRIKE: begin
                seq_cur       = seq_tgt;
                r.write_valid = 1'b1;
                r.write_servo = seq_servo;
                r.write_angle = seq_cur;
                seq_phase     = sss_pkg::PH_HOLD;
                seq_mark      = p.now_ms;
            end
            sss_pkg::PH_HOLD: begin
                if (p.now_ms - seq_mark >= {16'd0, hold_ms}) begin
                    seq_tgt       = rest_angle(seq_servo);
                    seq_phase     = sss_pkg::PH_RETURN;
                    seq_last_step = p.now_ms;
                end
            end
            sss_pkg::PH_RETURN: begin
                if (p.now_ms - seq_last_step >= {16'd0, ivl_ms}) begin
                    // Step toward rest, clamped; nine bits keep the sums exact
                    if (seq_cur < seq_tgt) begin
                        sum     = {1'b0, seq_cur} + {1'b0, deg_step};
                        seq_cur = (sum > {1'b0, seq_tgt}) ? seq_tgt : sum[7:0];
                    end else if (seq_cur > seq_tgt) begin
                        sum     = {1'b0, seq_tgt} + {1'b0, deg_step};
                        seq_cur = ({1'b0, seq_cur} < sum) ? seq_tgt : seq_cur - deg_step;
                    end
                    r.write_valid = 1'b1;
                    r.write_servo = seq_servo;
                    r.write_angle = seq_cur;
                    seq_last_step = p.now_ms;
                    if (seq_cur == seq_tgt) begin
                        seq_power = seq_power & ~(4'b0001 << seq_servo);
                        seq_phase = sss_pkg::PH_IDLE;
                        seq_armed = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        r.power_mask = seq_power;
        r.phase      = seq_phase;
        return r;
    endfunction

    // Driver: present queued polls, hold a stalled poll, idle at random
    always @(posedge clk) begin
        poll_t nxt;
        bit    hold;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                nxt = '{now_ms: now_ms, byte_valid: byte_valid, rx_byte: rx_byte};
                due_results.push_back(sequence_poll(nxt));
                polls_sent++;
            end
            hold = in_valid && in_stall;
            if (!hold) begin
                if (poll_q.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
                    nxt = poll_q.pop_front();
                    now_ms     <= nxt.now_ms;
                    byte_valid <= nxt.byte_valid;
                    rx_byte    <= nxt.rx_byte;
                    in_valid   <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: stall at random, compare each accepted result with the oldest due one
    always @(posedge clk) begin
        sss_pkg::res_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (write_valid)
                    writes_seen++;
                if (due_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with nothing due: expected none, actual phase %0d",
                             $time, phase);
                end else begin
                    want = due_results.pop_front();
                    check_field("byte_taken",  want.byte_taken,  byte_taken);
                    check_field("write_valid", want.write_valid, write_valid);
                    check_field("write_servo", want.write_servo, write_servo);
                    check_field("write_angle", want.write_angle, write_angle);
                    check_field("power_mask",  want.power_mask,  power_mask);
                    check_field("phase",       want.phase,       phase);
                end
            end
            out_stall <= !steady && ($urandom_range(0, 99) < 27);
        end
    end

    // Queue one poll, advancing the millisecond clock by gap first
    task automatic queue_poll(logic [31:0] gap, logic bv, logic [7:0] b);
        t_ms = t_ms + gap;
        poll_q.push_back('{now_ms: t_ms, byte_valid: bv, rx_byte: b});
    endtask

    // Write one register in the block and in the predictor
    task automatic write_reg(logic [sss_pkg::CFG_IDX_W-1:0] idx,
                             logic [sss_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            sss_pkg::REG_STRIKE_DELAY: dly_ms     = data;
            sss_pkg::REG_STRIKE_HOLD:  hold_ms    = data;
            sss_pkg::REG_STEP_IVL:     ivl_ms     = data;
            sss_pkg::REG_STEP_DEG:     deg_step   = data[7:0];
            sss_pkg::REG_STRIKE_ANGLE: strike_ang = data[7:0];
            sss_pkg::REG_LEFT_REST:    left_rest  = data[7:0];
            sss_pkg::REG_RIGHT_REST:   right_rest = data[7:0];
            default: ;
        endcase
    endtask

    // Load a full setting; upper bits of the byte registers carry junk to check masking
    task automatic load_setting(logic [15:0] dly, logic [15:0] hold, logic [15:0] ivl,
                                logic [7:0] deg, logic [7:0] strike, logic [7:0] left,
                                logic [7:0] right);
        write_reg(sss_pkg::REG_STRIKE_DELAY, dly);
        write_reg(sss_pkg::REG_STRIKE_HOLD,  hold);
        write_reg(sss_pkg::REG_STEP_IVL,     ivl);
        write_reg(sss_pkg::REG_STEP_DEG,     {8'($urandom), deg});
        write_reg(sss_pkg::REG_STRIKE_ANGLE, {8'($urandom), strike});
        write_reg(sss_pkg::REG_LEFT_REST,    {8'($urandom), left});
        write_reg(sss_pkg::REG_RIGHT_REST,   {8'($urandom), right});
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Wait until every queued poll has gone in and every due result has come out
    task automatic drain();
        while (poll_q.size() != 0 || in_valid || due_results.size() != 0)
            @(posedge clk);
    endtask

    // Random polls: mostly short time steps near the ramp interval so sequences run
    // through, some steps on the scale of the delay and hold, a few long jumps and
    // full 32-bit jumps that wrap the clock. Bytes are mostly strike commands.
    task automatic random_polls(int n);
        int unsigned fine;
        int unsigned coarse;
        int unsigned pick;
        logic [31:0] gap;
        logic [7:0]  b;
        fine   = ivl_ms + 3;
        coarse = ((dly_ms > hold_ms) ? dly_ms : hold_ms) / 4 + 1;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                gap = $urandom_range(0, fine);
            else if (pick < 85)
                gap = $urandom_range(0, coarse);
            else if (pick < 95)
                gap = $urandom_range(0, 70000);
            else
                gap = $urandom;
            b = ($urandom_range(0, 99) < 70) ? sss_pkg::CMD_FIRST + 8'($urandom_range(0, 3))
                                              : 8'($urandom);
            queue_poll(gap, $urandom_range(0, 99) < 40, b);
        end
    endtask

    initial begin
        // Predictor starts from the block's reset state
        dly_ms     = sss_pkg::RST_STRIKE_DELAY;
        hold_ms    = sss_pkg::RST_STRIKE_HOLD;
        ivl_ms     = sss_pkg::RST_STEP_IVL;
        deg_step   = sss_pkg::RST_STEP_DEG;
        strike_ang = sss_pkg::RST_STRIKE_ANGLE;
        left_rest  = sss_pkg::RST_LEFT_REST;
        right_rest = sss_pkg::RST_RIGHT_REST;
        seq_phase     = sss_pkg::PH_IDLE;
        seq_servo     = '0;
        seq_armed     = 1'b0;
        seq_cur       = '0;
        seq_tgt       = '0;
        seq_mark      = '0;
        seq_last_step = '0;
        seq_power     = '0;
        // Start just below the wrap so the first strike spans it
        t_ms = 32'hFFFF_FF80;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: dropped bytes, one full strike on servo 0, busy bytes ignored
        queue_poll(0,  1'b0, sss_pkg::CMD_FIRST);   // byte not flagged: nothing taken
        queue_poll(1,  1'b1, 8'h00);                // junk bytes are taken and dropped
        queue_poll(1,  1'b1, 8'hFF);
        queue_poll(1,  1'b1, sss_pkg::CMD_FIRST - 8'd1);
        queue_poll(1,  1'b1, sss_pkg::CMD_LAST + 8'd1);
        queue_poll(1,  1'b1, sss_pkg::CMD_FIRST);   // arm servo 0
        queue_poll(99, 1'b1, sss_pkg::CMD_FIRST + 8'd1); // one short of the delay, byte left
        queue_poll(1,  1'b0, 8'h00);                // delay met: attach
        queue_poll(0,  1'b0, 8'h00);                // jump to strike angle
        queue_poll(299, 1'b0, 8'h00);               // one short of the hold
        queue_poll(1,  1'b1, sss_pkg::CMD_LAST);    // hold met: start return
        queue_poll(9,  1'b0, 8'h00);                // interval not yet met
        queue_poll(1,  1'b0, 8'h00);                // first ramp step
        queue_poll(10, 1'b0, 8'h00);
        queue_poll(200, 1'b0, 8'h00);
        random_polls(120);
        drain();

        // Low extremes: zero delay attaches in the command poll; servo 3 rests at
        // the strike angle so its first return step ends the strike
        load_setting(16'd0, 16'd0, 16'd0, 8'd180, 8'd180, 8'd0, 8'd180);
        queue_poll(5, 1'b1, sss_pkg::CMD_LAST);
        queue_poll(0, 1'b0, 8'h00);
        queue_poll(0, 1'b0, 8'h00);
        queue_poll(0, 1'b0, 8'h00);
        queue_poll(0, 1'b1, sss_pkg::CMD_FIRST + 8'd2);
        queue_poll(0, 1'b0, 8'h00);
        queue_poll(0, 1'b0, 8'h00);
        queue_poll(0, 1'b0, 8'h00);
        random_polls(120);
        drain();

        // High extremes of every timer
        load_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd180, 8'd0, 8'd180, 8'd0);
        random_polls(120);
        drain();

        // Rest equals strike on both sides
        load_setting(16'd20, 16'd30, 16'd4, 8'd7, 8'd90, 8'd90, 8'd90);
        random_polls(120);
        drain();

        // Zero step: left servos already at rest finish, right servos ramp forever
        load_setting(16'd10, 16'd10, 16'd2, 8'd0, 8'd120, 8'd120, 8'd30);
        random_polls(120);
        drain();

        // Angles and step above 180, used as given
        load_setting(16'd15, 16'd25, 16'd3, 8'd255, 8'd250, 8'd255, 8'd200);
        random_polls(120);
        drain();

        // Random settings; the first uses single-degree steps, one runs with no idling
        for (int k = 0; k < 8; k++) begin
            steady = (k == 4);
            load_setting(16'($urandom_range(0, 300)), 16'($urandom_range(0, 500)),
                         16'($urandom_range(0, 30)),
                         (k == 0) ? 8'd1 : 8'($urandom_range(1, 180)),
                         8'($urandom_range(0, 180)), 8'($urandom_range(0, 180)),
                         8'($urandom_range(0, 180)));
            random_polls(130);
            drain();
        end
        steady = 1'b0;

        // Let the pipeline settle and catch any stray result
        repeat (10) @(posedge clk);
        if (due_results.size() != 0) begin
            mismatches++;
            $display("%0t: results left over: expected 0, actual %0d",
                     $time, due_results.size());
        end
        $display("Covered %0d polls and %0d results over %0d register settings",
                 polls_sent, results_seen, settings_used);
        $display("Strikes started: %0d, servo writes seen: %0d", strikes_started, writes_seen);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog well beyond the slowest correct run
    initial begin
        #5_000_000;
        $display("Timeout with %0d results still due", due_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
